### src/key_merge_sorter_core_defines.svh
// assertion macros for the key merge sorter top level
`ifndef KEY_MERGE_SORTER_CORE_DEFINES_SVH
`define KEY_MERGE_SORTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KMS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KMS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/kms_pkg.sv
// shared constants and types of the key merge sorter
`timescale 1ns / 1ps
package kms_pkg;

    localparam int KMS_MAX_ITEMS = 64;
    localparam int KMS_KEY_BITS  = 32;
    localparam int TAG_BITS      = 16;
    localparam int PORT_KEY_BITS = 32;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MERGE_INIT,
        OP_READ_RIGHT,
        OP_CAP_RIGHT,
        OP_STEP,
        OP_CAP,
        OP_COPY,
        OP_EMIT,
        OP_CLEAR
    } op_t;

    // progress of one node of the split tree
    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_MERGE
    } phase_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic copy_done;
        logic emit_done;
    } status_t;

endpackage

### src/kms_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module kms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/kms_datapath.sv
// item store, merge scratch, merge pointers and result registers
`timescale 1ns / 1ps
module kms_datapath
    import kms_pkg::*;
#(
    parameter int MAX_ITEMS = KMS_MAX_ITEMS,
    parameter int KEY_BITS  = KMS_KEY_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    input  logic [$clog2(MAX_ITEMS)-1:0]   base,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] left_len,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] right_len,
    output status_t                        status,
    output logic [$clog2(MAX_ITEMS+1)-1:0] count,
    input  logic [PORT_KEY_BITS-1:0]       sort_key,
    input  logic [TAG_BITS-1:0]            item_tag,
    output logic                           result_valid,
    output logic [PORT_KEY_BITS-1:0]       sorted_key,
    output logic [TAG_BITS-1:0]            sorted_tag,
    output logic                           run_end,
    output logic                           overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int EW = KEY_BITS + TAG_BITS;

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] ll_reg, ll_next, rl_reg, rl_next;
    logic [CW-1:0] li_reg, li_next, ri_reg, ri_next, k_reg, k_next;
    logic [CW-1:0] rk_reg, rk_next, ek_reg, ek_next;
    logic          wpend_reg, wpend_next;
    logic [AW-1:0] waddr_reg, waddr_next;
    logic [EW-1:0] head_l_reg, head_l_next, head_r_reg, head_r_next;
    logic          side_reg, side_next;
    logic          ovalid_reg, ovalid_next, oend_reg, oend_next;

    logic [CW-1:0] total;
    logic          take_left;
    logic [KEY_BITS+PORT_KEY_BITS-1:0] key_wide_in, key_wide_out;
    logic [EW-1:0] store_wdata, store_rdata, scr_rdata, scr_wdata;
    logic [AW-1:0] store_waddr, store_raddr;
    logic          store_we, scr_we;

    assign total = ll_reg + rl_reg;
    assign take_left = (li_reg != ll_reg) &&
                       ((ri_reg == rl_reg) ||
                        (head_l_reg[EW-1:TAG_BITS] < head_r_reg[EW-1:TAG_BITS]));

    assign key_wide_in  = {{KEY_BITS{1'b0}}, sort_key};
    assign key_wide_out = {{PORT_KEY_BITS{1'b0}}, store_rdata[EW-1:TAG_BITS]};

    assign store_we    = ((cmd.op == OP_LOAD) && (count_reg < CW'(MAX_ITEMS))) || wpend_reg;
    assign store_waddr = wpend_reg ? waddr_reg : count_reg[AW-1:0];
    assign store_wdata = wpend_reg ? scr_rdata : {key_wide_in[KEY_BITS-1:0], item_tag};

    assign scr_we    = (cmd.op == OP_STEP);
    assign scr_wdata = take_left ? head_l_reg : head_r_reg;

    always_comb
    begin
        case (cmd.op)
            OP_MERGE_INIT: store_raddr = base;
            OP_READ_RIGHT: store_raddr = base_reg + ll_reg[AW-1:0];
            OP_STEP:
            begin
                if (take_left)
                begin
                    store_raddr = base_reg + li_reg[AW-1:0] + AW'(1);
                end
                else
                begin
                    store_raddr = base_reg + ll_reg[AW-1:0] + ri_reg[AW-1:0] + AW'(1);
                end
            end
            OP_EMIT:       store_raddr = ek_reg[AW-1:0];
            default:       store_raddr = '0;
        endcase
    end

    kms_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    kms_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_scratch (
        .clk   (clk),
        .we    (scr_we),
        .waddr (k_reg[AW-1:0]),
        .wdata (scr_wdata),
        .raddr (rk_reg[AW-1:0]),
        .rdata (scr_rdata)
    );

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        base_next    = base_reg;
        ll_next      = ll_reg;
        rl_next      = rl_reg;
        li_next      = li_reg;
        ri_next      = ri_reg;
        k_next       = k_reg;
        rk_next      = rk_reg;
        ek_next      = ek_reg;
        wpend_next   = 1'b0;
        waddr_next   = waddr_reg;
        head_l_next  = head_l_reg;
        head_r_next  = head_r_reg;
        side_next    = side_reg;
        ovalid_next  = 1'b0;
        oend_next    = oend_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                if (count_reg < CW'(MAX_ITEMS))
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            OP_MERGE_INIT:
            begin
                base_next = base;
                ll_next   = left_len;
                rl_next   = right_len;
                li_next   = '0;
                ri_next   = '0;
                k_next    = '0;
                rk_next   = '0;
            end
            OP_READ_RIGHT: head_l_next = store_rdata;
            OP_CAP_RIGHT:  head_r_next = store_rdata;
            OP_STEP:
            begin
                side_next = take_left;
                k_next    = k_reg + CW'(1);
                if (take_left)
                begin
                    li_next = li_reg + CW'(1);
                end
                else
                begin
                    ri_next = ri_reg + CW'(1);
                end
            end
            OP_CAP:
            begin
                if (side_reg)
                begin
                    head_l_next = store_rdata;
                end
                else
                begin
                    head_r_next = store_rdata;
                end
            end
            OP_COPY:
            begin
                if (rk_reg < total)
                begin
                    rk_next    = rk_reg + CW'(1);
                    wpend_next = 1'b1;
                    waddr_next = base_reg + rk_reg[AW-1:0];
                end
            end
            OP_EMIT:
            begin
                if (ek_reg < count_reg)
                begin
                    ek_next     = ek_reg + CW'(1);
                    ovalid_next = 1'b1;
                    oend_next   = ((ek_reg + CW'(1)) == count_reg);
                end
            end
            OP_CLEAR:
            begin
                count_next   = '0;
                dropped_next = 1'b0;
                ek_next      = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            ek_reg      <= '0;
            rk_reg      <= '0;
            wpend_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            ek_reg      <= ek_next;
            rk_reg      <= rk_next;
            wpend_reg   <= wpend_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        ll_reg     <= ll_next;
        rl_reg     <= rl_next;
        li_reg     <= li_next;
        ri_reg     <= ri_next;
        k_reg      <= k_next;
        waddr_reg  <= waddr_next;
        head_l_reg <= head_l_next;
        head_r_reg <= head_r_next;
        side_reg   <= side_next;
        oend_reg   <= oend_next;
    end

    assign status.step_last = ((k_reg + CW'(1)) == total);
    assign status.copy_done = (rk_reg == total) && !wpend_reg;
    assign status.emit_done = (ek_reg == count_reg);
    assign count            = count_reg;

    assign result_valid = ovalid_reg;
    assign sorted_key   = key_wide_out[PORT_KEY_BITS-1:0];
    assign sorted_tag   = store_rdata[TAG_BITS-1:0];
    assign run_end      = oend_reg;
    assign overflow     = dropped_reg;

endmodule

### src/kms_controller.sv
// sequencer: load, top-down split walk with a node stack, merge, copy, emit
`timescale 1ns / 1ps
module kms_controller
    import kms_pkg::*;
#(
    parameter int MAX_ITEMS = KMS_MAX_ITEMS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           final_item,
    output logic                           busy,
    output cmd_t                           cmd,
    output logic [$clog2(MAX_ITEMS)-1:0]   base,
    output logic [$clog2(MAX_ITEMS+1)-1:0] left_len,
    output logic [$clog2(MAX_ITEMS+1)-1:0] right_len,
    input  status_t                        status,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] count
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int SD  = $clog2(MAX_ITEMS) + 1;
    localparam int SPW = $clog2(SD);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_INIT = 9'b000000010,
        S_TRAV = 9'b000000100,
        S_RDR  = 9'b000001000,
        S_CAPR = 9'b000010000,
        S_STEP = 9'b000100000,
        S_CAP  = 9'b001000000,
        S_COPY = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t         state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [AW-1:0]  stk_base_reg [SD];
    logic [AW-1:0]  stk_base_next [SD];
    logic [CW-1:0]  stk_len_reg [SD];
    logic [CW-1:0]  stk_len_next [SD];
    phase_t         stk_ph_reg [SD];
    phase_t         stk_ph_next [SD];

    logic [AW-1:0] top_base;
    logic [CW-1:0] top_len, half_len;
    phase_t        top_ph;
    logic [CW:0]   half_wide;

    assign top_base  = stk_base_reg[sp_reg];
    assign top_len   = stk_len_reg[sp_reg];
    assign top_ph    = stk_ph_reg[sp_reg];
    assign half_wide = ({1'b0, top_len} + (CW+1)'(1)) >> 1;
    assign half_len  = half_wide[CW-1:0];

    assign base      = top_base;
    assign left_len  = half_len;
    assign right_len = top_len - half_len;
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        stk_base_next = stk_base_reg;
        stk_len_next  = stk_len_reg;
        stk_ph_next   = stk_ph_reg;
        cmd.op        = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (final_item)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                sp_next          = '0;
                stk_base_next[0] = '0;
                stk_len_next[0]  = count;
                stk_ph_next[0]   = PH_LEFT;
                state_next       = S_TRAV;
            end
            S_TRAV:
            begin
                if (top_len <= CW'(1))
                begin
                    // leaf: nothing to merge, return to parent
                    if (sp_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sp_next = sp_reg - SPW'(1);
                    end
                end
                else
                begin
                    case (top_ph)
                        PH_LEFT:
                        begin
                            stk_ph_next[sp_reg]             = PH_RIGHT;
                            stk_base_next[sp_reg + SPW'(1)] = top_base;
                            stk_len_next[sp_reg + SPW'(1)]  = half_len;
                            stk_ph_next[sp_reg + SPW'(1)]   = PH_LEFT;
                            sp_next                         = sp_reg + SPW'(1);
                        end
                        PH_RIGHT:
                        begin
                            stk_ph_next[sp_reg]             = PH_MERGE;
                            stk_base_next[sp_reg + SPW'(1)] = top_base + half_len[AW-1:0];
                            stk_len_next[sp_reg + SPW'(1)]  = top_len - half_len;
                            stk_ph_next[sp_reg + SPW'(1)]   = PH_LEFT;
                            sp_next                         = sp_reg + SPW'(1);
                        end
                        PH_MERGE:
                        begin
                            cmd.op     = OP_MERGE_INIT;
                            state_next = S_RDR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDR:
            begin
                cmd.op     = OP_READ_RIGHT;
                state_next = S_CAPR;
            end
            S_CAPR:
            begin
                cmd.op     = OP_CAP_RIGHT;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = status.step_last ? S_COPY : S_CAP;
            end
            S_CAP:
            begin
                cmd.op     = OP_CAP;
                state_next = S_STEP;
            end
            S_COPY:
            begin
                cmd.op = OP_COPY;
                if (status.copy_done)
                begin
                    if (sp_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sp_next    = sp_reg - SPW'(1);
                        state_next = S_TRAV;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.emit_done)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stk_base_reg <= stk_base_next;
        stk_len_reg  <= stk_len_next;
        stk_ph_reg   <= stk_ph_next;
    end

endmodule

### src/key_merge_sorter_core.sv
// top level of the key merge sorter: controller plus datapath
// load: one request per cycle while busy is low; a request with final_item set starts the sort
// sort: top-down merge; each merge reads both heads, then alternates step and capture per element,
//   then copies the scratch back, its pace set by the single read port of the item store
// emit: n results on consecutive cycles from the registered store read, then busy drops
// results come with a one-cycle strobe; the receiver cannot stall them
// reset (rst_n, async, active low) empties the store, clears the overflow flag and idles
`timescale 1ns / 1ps
`include "key_merge_sorter_core_defines.svh"
module key_merge_sorter_core
    import kms_pkg::*;
#(
    parameter int MAX_ITEMS = KMS_MAX_ITEMS,
    parameter int KEY_BITS  = KMS_KEY_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [PORT_KEY_BITS-1:0] sort_key,
    input  logic [TAG_BITS-1:0]      item_tag,
    input  logic                     final_item,
    output logic                     result_valid,
    output logic [PORT_KEY_BITS-1:0] sorted_key,
    output logic [TAG_BITS-1:0]      sorted_tag,
    output logic                     run_end,
    output logic                     overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    // command / status between sequencer and datapath
    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] merge_base;
    logic [CW-1:0] merge_left_len;
    logic [CW-1:0] merge_right_len;
    logic [CW-1:0] item_count;

    // sequencer: holds the split-tree stack and walks it in post order
    kms_controller #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .final_item (final_item),
        .busy       (busy),
        .cmd        (cmd),
        .base       (merge_base),
        .left_len   (merge_left_len),
        .right_len  (merge_right_len),
        .status     (status),
        .count      (item_count)
    );

    // datapath: item store, scratch, merge heads and result registers
    kms_datapath #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .base         (merge_base),
        .left_len     (merge_left_len),
        .right_len    (merge_right_len),
        .status       (status),
        .count        (item_count),
        .sort_key     (sort_key),
        .item_tag     (item_tag),
        .result_valid (result_valid),
        .sorted_key   (sorted_key),
        .sorted_tag   (sorted_tag),
        .run_end      (run_end),
        .overflow     (overflow)
    );

    // a final request always starts a sort
    `KMS_ASSERT_NEXT(a_final_starts, start && !busy && final_item, busy, "final request did not start a sort")
    // results only appear while the block is busy
    `KMS_ASSERT_NOW(a_result_in_busy, result_valid, busy, "result strobe while idle")
    // the last result closes the set and frees the block
    `KMS_ASSERT_NEXT(a_end_frees, result_valid && run_end, !result_valid && !busy, "block did not idle after last result")

endmodule

### test/tb_top.sv
// testbench for the key merge sorter: random sets, own merge sort predictor, scoreboard
`timescale 1ns / 1ps

// holds the expected sorted results and the set being loaded
class sort_scoreboard;
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] tag;
    } entry_t;

    entry_t set_items[$];
    entry_t work[];
    entry_t scratch[];
    logic   lost;
    logic [49:0] expected_results[$];
    int     errors;

    function new();
        lost = 1'b0;
        errors = 0;
    endfunction

    // top-down merge sort, left part gets the larger half, ties go right first
    function void sort_part(int base, int len);
        int left_len;
        int li;
        int ri;
        bool_pick: begin
        end
        if (len <= 1)
            return;
        left_len = (len + 1) / 2;
        sort_part(base, left_len);
        sort_part(base + left_len, len - left_len);
        li = 0;
        ri = 0;
        for (int k = 0; k < len; k++)
        begin
            if ((li != left_len) &&
                ((ri == len - left_len) ||
                 (work[base + li].key < work[base + left_len + ri].key)))
            begin
                scratch[k] = work[base + li];
                li = li + 1;
            end
            else
            begin
                scratch[k] = work[base + left_len + ri];
                ri = ri + 1;
            end
        end
        for (int k = 0; k < len; k++)
            work[base + k] = scratch[k];
    endfunction

    // note one accepted request
    function void note_request(logic [31:0] key, logic [15:0] tag, logic last);
        entry_t e;
        int n;
        e.key = key;
        e.tag = tag;
        if (set_items.size() < 64)
            set_items.insert(set_items.size(), e);
        else
            lost = 1'b1;
        if (!last)
            return;
        n = set_items.size();
        work = new[n];
        scratch = new[n];
        foreach (set_items[i])
            work[i] = set_items[i];
        sort_part(0, n);
        for (int k = 0; k < n; k++)
            expected_results.insert(expected_results.size(),
                                    {work[k].key, work[k].tag, k == n - 1, lost});
        set_items.delete();
        lost = 1'b0;
    endfunction

    // compare one strobed result with the oldest expectation
    function void check_result(logic [31:0] key, logic [15:0] tag, logic last, logic ovf);
        logic [49:0] exp_r;
        logic [49:0] act;
        act = {key, tag, last, ovf};
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, act);
            errors++;
            return;
        end
        exp_r = expected_results.pop_front();
        if (exp_r[49:18] !== key)
        begin
            $display("%0t: sorted_key expected %h actual %h", $time, exp_r[49:18], key);
            errors++;
        end
        if (exp_r[17:2] !== tag)
        begin
            $display("%0t: sorted_tag expected %h actual %h", $time, exp_r[17:2], tag);
            errors++;
        end
        if (exp_r[1] !== last)
        begin
            $display("%0t: run_end expected %b actual %b", $time, exp_r[1], last);
            errors++;
        end
        if (exp_r[0] !== ovf)
        begin
            $display("%0t: overflow expected %b actual %b", $time, exp_r[0], ovf);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import kms_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] sort_key;
    logic [15:0] item_tag;
    logic        final_item;
    logic        result_valid;
    logic [31:0] sorted_key;
    logic [15:0] sorted_tag;
    logic        run_end;
    logic        overflow;

    sort_scoreboard board;
    int idle_pct;
    int cycle_count;

    key_merge_sorter_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sort_key(sort_key), .item_tag(item_tag), .final_item(final_item),
        .result_valid(result_valid), .sorted_key(sorted_key), .sorted_tag(sorted_tag),
        .run_end(run_end), .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // results cannot be held off, so just check every strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(sorted_key, sorted_tag, run_end, overflow);
    end

    // watchdog: fails the run once the cycle counter passes its limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // issue one request, with random idle cycles in front of it
    task automatic send_request(logic [31:0] key, logic [15:0] tag, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        sort_key   <= key;
        item_tag   <= tag;
        final_item <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // request taken at this edge
        board.note_request(key, tag, last);
    endtask

    // keys with many ties and extremes mixed in
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // one whole set of len requests, final mark on the last
    task automatic send_set(int len);
        for (int i = 0; i < len; i++)
            send_request(pick_key(), 16'($urandom), i == len - 1);
    endtask

    int sent;
    int len;

    initial
    begin
        board = new();
        cycle_count = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sort_key = '0;
        item_tag = '0;
        final_item = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single item, extremes, equal keys, exact fill, overflow
        send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_request(32'h0, 16'h0, 1'b1);
        send_request(32'h5, 16'h1, 1'b0);
        send_request(32'h5, 16'h2, 1'b0);
        send_request(32'h5, 16'h3, 1'b1);
        send_request(32'hFFFF_FFFF, 16'hAAAA, 1'b0);
        send_request(32'h0, 16'h5555, 1'b1);
        send_set(64);
        send_set(66);
        // overflow with the dropped item being the final one
        send_set(65);

        // random sets under three idle settings
        sent = 0;
        while (sent < 300)
        begin
            idle_pct = (sent < 100) ? 37 : (sent < 200) ? 85 : 0;
            case ($urandom_range(9))
                0: len = $urandom_range(70, 64);
                1: len = 1;
                default: len = $urandom_range(12, 2);
            endcase
            send_set(len);
            sent += len;
        end
        start <= 1'b0;

        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
+incdir+src
src/kms_pkg.sv
src/kms_ram.sv
src/kms_datapath.sv
src/kms_controller.sv
src/key_merge_sorter_core.sv
test/tb_top.sv
